[hw/rtl/point_line_foot_and_distance_top_defines.svh]
// Assertion macros for the point/line foot and distance block.
`ifndef POINT_LINE_FOOT_AND_DISTANCE_TOP_DEFINES_SVH
`define POINT_LINE_FOOT_AND_DISTANCE_TOP_DEFINES_SVH

// Clocked on clk_i, off while rst_ni is low.
`define PLFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define PLFD_ASSERT_IMP(lbl, ante, cons, msg) \
  `PLFD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[hw/rtl/plfd_pkg.sv]
package plfd_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] line_x;
    logic signed [31:0] line_y;
    logic signed [31:0] line_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
    logic signed [31:0] foot_z;
    logic        [31:0] distance;
    logic               degenerate;
    logic               saturated;
  } res_t;

  // |D|^2 width; at most 3*2^62.
  localparam int unsigned DenW    = 64;
  // Foot quotient stays below 2^33 (bounded by |P-O|).
  localparam int unsigned FootQw  = 33;
  localparam int unsigned FootNw  = 96;
  // 4*|PxD|^2/|D|^2 stays below 2^68.
  localparam int unsigned DistQw  = 68;
  localparam int unsigned DistNw  = 132;
  localparam int unsigned FrontStages = 7;
  // Foot path is shorter than divide+sqrt; this realigns it.
  localparam int unsigned FootTail = DistQw + DistQw / 2 - FootQw - 2;
  localparam int unsigned Latency  = FrontStages + DistQw + DistQw / 2 + 1;

endpackage

[hw/rtl/plfd_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Requires num_i < den_i * 2^QW.
module plfd_div #(
  parameter int unsigned NW = 96,
  parameter int unsigned DW = 64,
  parameter int unsigned QW = 33
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] den_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_s;
    logic [DW-1:0] den_s;
    logic [QW-1:0] low_s;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_s = DW'(num_i[NW-1:QW]);
      assign low_s = num_i[QW-1:0];
      assign den_s = den_i;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign low_s = low_q[k-1];
      assign den_s = den_q[k-1];
    end

    assign trial = {rem_s, low_s[QW-1]};
    assign diff  = trial - {1'b0, den_s};

    always_ff @(posedge clk_i) begin
      if (trial >= {1'b0, den_s}) begin
        rem_q[k] <= diff[DW-1:0];
        low_q[k] <= {low_s[QW-2:0], 1'b1};
      end else begin
        rem_q[k] <= trial[DW-1:0];
        low_q[k] <= {low_s[QW-2:0], 1'b0};
      end
      den_q[k] <= den_s;
    end
  end

  assign quo_o = low_q[QW-1];
  assign rem_o = rem_q[QW-1];
  assign den_o = den_q[QW-1];

endmodule

[hw/rtl/plfd_sqrt.sv]
// Pipelined integer square root (floor), two operand bits per stage.
module plfd_sqrt #(
  parameter int unsigned IW = 68
) (
  input  logic            clk_i,
  input  logic [IW-1:0]   op_i,
  output logic [IW/2-1:0] root_o
);

  localparam int unsigned RN = IW / 2;
  localparam int unsigned RW = RN + 3;

  logic [RW-1:0] rem_q  [RN];
  logic [RN-1:0] root_q [RN];
  logic [IW-1:0] op_q   [RN];

  for (genvar k = 0; k < RN; k++) begin : g_step
    logic [RW-1:0] rem_s;
    logic [RN-1:0] root_s;
    logic [IW-1:0] op_s;
    logic [RW-1:0] t;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_s  = '0;
      assign root_s = '0;
      assign op_s   = op_i;
    end else begin : g_next
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign op_s   = op_q[k-1];
    end

    assign t     = {rem_s[RW-3:0], op_s[IW-1:IW-2]};
    assign trial = RW'({root_s, 2'b01});

    always_ff @(posedge clk_i) begin
      if (t >= trial) begin
        rem_q[k]  <= t - trial;
        root_q[k] <= {root_s[RN-2:0], 1'b1};
      end else begin
        rem_q[k]  <= t;
        root_q[k] <= {root_s[RN-2:0], 1'b0};
      end
      op_q[k] <= {op_s[IW-3:0], 2'b00};
    end
  end

  assign root_o = root_q[RN-1];

endmodule

[hw/rtl/plfd_delay.sv]
// Fixed-length delay line.
module plfd_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        line_q[k] <= '0;
      end
    end else begin
      line_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign q_o = line_q[N-1];

endmodule

[hw/rtl/point_line_foot_and_distance_top.sv]
// Channel   Ports                      Direction  Handshake
// command   start_i, busy_o, cmd_i     in         taken when start_i && !busy_o
// result    done_o, res_o              out        one cycle, strobe done_o
//
// Fully pipelined: one item per cycle, busy_o is always low.
// An accepted item passes the front stages S0..S6, the 68-stage divider for 4|PxD|^2/|D|^2,
// the 34-stage square root and the output register before done_o rises.
// Reset clears the valid chain and the delay lines; pipeline data registers are unreset.
// There is no stall: results appear in accept order, one per item.
`include "point_line_foot_and_distance_top_defines.svh"

module point_line_foot_and_distance_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  plfd_pkg::cmd_t    cmd_i,
  output logic              done_o,
  output plfd_pkg::res_t    res_o
);

  localparam int unsigned DW  = plfd_pkg::DenW;
  localparam int unsigned FQ  = plfd_pkg::FootQw;
  localparam int unsigned FN  = plfd_pkg::FootNw;
  localparam int unsigned DQ  = plfd_pkg::DistQw;
  localparam int unsigned DN  = plfd_pkg::DistNw;
  localparam int unsigned RN  = DQ / 2;
  // Foot sideband: line point, three signs, degenerate.
  localparam int unsigned SbW = 3 * 32 + 3 + 1;
  // Finished foot: three coordinates, clip flag, degenerate.
  localparam int unsigned FtW = 3 * 32 + 2;

  assign busy_o = 1'b0;

  // Valid chain over the front stages S0..S6.
  logic [plfd_pkg::FrontStages-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[plfd_pkg::FrontStages-2:0], start_i};
    end
  end

  // S0: register operands, form V = P - O.
  logic signed [31:0] pin [3];
  logic signed [31:0] oin [3];
  logic signed [31:0] din [3];

  always_comb begin
    pin[0] = cmd_i.point_x; pin[1] = cmd_i.point_y; pin[2] = cmd_i.point_z;
    oin[0] = cmd_i.line_x;  oin[1] = cmd_i.line_y;  oin[2] = cmd_i.line_z;
    din[0] = cmd_i.dir_x;   din[1] = cmd_i.dir_y;   din[2] = cmd_i.dir_z;
  end

  logic signed [32:0] v0_q [3];
  logic signed [31:0] d0_q [3];
  logic signed [31:0] o0_q [3];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 3; i++) begin
        v0_q[i] <= 33'(pin[i]) - 33'(oin[i]);
        d0_q[i] <= din[i];
        o0_q[i] <= oin[i];
      end
    end
  end

  // S1: all first-level products.
  logic        [63:0] dd1_q [3];
  logic signed [64:0] dp1_q [3];
  logic signed [64:0] cp1_q [6];
  logic signed [65:0] vv1_q [3];
  logic signed [31:0] o1_q  [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dd1_q[i] <= 64'(d0_q[i]) * 64'(d0_q[i]);
      dp1_q[i] <= 65'(v0_q[i]) * 65'(d0_q[i]);
      vv1_q[i] <= 66'(v0_q[i]) * 66'(v0_q[i]);
      o1_q[i]  <= o0_q[i];
    end
    // cross product terms, c_k = v_a*d_b - v_b*d_a
    cp1_q[0] <= 65'(v0_q[1]) * 65'(d0_q[2]);
    cp1_q[1] <= 65'(v0_q[2]) * 65'(d0_q[1]);
    cp1_q[2] <= 65'(v0_q[2]) * 65'(d0_q[0]);
    cp1_q[3] <= 65'(v0_q[0]) * 65'(d0_q[2]);
    cp1_q[4] <= 65'(v0_q[0]) * 65'(d0_q[1]);
    cp1_q[5] <= 65'(v0_q[1]) * 65'(d0_q[0]);
  end

  // S2: sums: |D|^2, P-O dot D, cross product, |P-O|^2.
  logic        [63:0] dd2_q;
  logic signed [66:0] dot2_q;
  logic signed [65:0] c2_q [3];
  logic        [66:0] nnd2_q;
  logic signed [31:0] o2_q [3];
  logic signed [31:0] d1_q [3];
  logic signed [31:0] d2_q [3];

  always_ff @(posedge clk_i) begin
    dd2_q  <= dd1_q[0] + dd1_q[1] + dd1_q[2];
    dot2_q <= 67'(dp1_q[0]) + 67'(dp1_q[1]) + 67'(dp1_q[2]);
    nnd2_q <= 67'(vv1_q[0]) + 67'(vv1_q[1]) + 67'(vv1_q[2]);
    for (int k = 0; k < 3; k++) begin
      c2_q[k] <= 66'(cp1_q[2*k]) - 66'(cp1_q[2*k+1]);
      o2_q[k] <= o1_q[k];
      d1_q[k] <= d0_q[k];
      d2_q[k] <= d1_q[k];
    end
  end

  // S3: magnitudes and signs, zero-direction test.
  logic               degen3_q;
  logic        [63:0] dd3_q;
  logic               dneg_dot3_q;
  logic        [64:0] dot_mag3_q;
  logic        [31:0] dmag3_q [3];
  logic               dneg3_q [3];
  logic        [64:0] cmag3_q [3];
  logic        [66:0] nnd3_q;
  logic signed [31:0] o3_q [3];

  always_ff @(posedge clk_i) begin
    degen3_q    <= (dd2_q == '0);
    dd3_q       <= dd2_q;
    dneg_dot3_q <= dot2_q[66];
    dot_mag3_q  <= dot2_q[66] ? 65'(-dot2_q) : 65'(dot2_q);
    nnd3_q      <= nnd2_q;
    for (int i = 0; i < 3; i++) begin
      dmag3_q[i] <= d2_q[i][31] ? 32'(-d2_q[i]) : 32'(d2_q[i]);
      dneg3_q[i] <= d2_q[i][31];
      cmag3_q[i] <= c2_q[i][65] ? 65'(-c2_q[i]) : 65'(c2_q[i]);
      o3_q[i]    <= o2_q[i];
    end
  end

  // S4: split second-level products (dot*d_i and c_i^2) into halves.
  logic        [64:0] mlo4_q [3];
  logic        [63:0] mhi4_q [3];
  logic               sgn4_q [3];
  logic        [63:0] chh4_q [3];
  logic        [64:0] chl4_q [3];
  logic        [65:0] cll4_q [3];
  logic               degen4_q;
  logic        [63:0] dd4_q;
  logic        [66:0] nnd4_q;
  logic signed [31:0] o4_q [3];

  always_ff @(posedge clk_i) begin
    degen4_q <= degen3_q;
    dd4_q    <= dd3_q;
    nnd4_q   <= nnd3_q;
    for (int i = 0; i < 3; i++) begin
      mlo4_q[i] <= 65'(dot_mag3_q[32:0]) * 65'(dmag3_q[i]);
      mhi4_q[i] <= 64'(dot_mag3_q[64:33]) * 64'(dmag3_q[i]);
      sgn4_q[i] <= dneg_dot3_q ^ dneg3_q[i];
      chh4_q[i] <= 64'(cmag3_q[i][64:33]) * 64'(cmag3_q[i][64:33]);
      chl4_q[i] <= 65'(cmag3_q[i][64:33]) * 65'(cmag3_q[i][32:0]);
      cll4_q[i] <= 66'(cmag3_q[i][32:0]) * 66'(cmag3_q[i][32:0]);
      o4_q[i]   <= o3_q[i];
    end
  end

  // S5: recombine halves.
  logic      [FN-1:0] num5_q [3];
  logic       [129:0] sq5_q  [3];
  logic               sgn5_q [3];
  logic               degen5_q;
  logic        [63:0] dd5_q;
  logic        [66:0] nnd5_q;
  logic signed [31:0] o5_q [3];

  always_ff @(posedge clk_i) begin
    degen5_q <= degen4_q;
    dd5_q    <= dd4_q;
    nnd5_q   <= nnd4_q;
    for (int i = 0; i < 3; i++) begin
      num5_q[i] <= (FN'(mhi4_q[i]) << 33) + FN'(mlo4_q[i]);
      sq5_q[i]  <= (130'(chh4_q[i]) << 66) + (130'(chl4_q[i]) << 34) + 130'(cll4_q[i]);
      sgn5_q[i] <= sgn4_q[i];
      o5_q[i]   <= o4_q[i];
    end
  end

  // S6: pick the distance numerator/denominator (4|P-O|^2 / 1 when degenerate).
  logic      [DN-1:0] nnc;
  logic      [DN-1:0] nn4_6_q;
  logic      [DW-1:0] den6_q;
  logic      [DW-1:0] ddf6_q;
  logic      [FN-1:0] num6_q [3];
  logic               sgn6_q [3];
  logic               degen6_q;
  logic signed [31:0] o6_q [3];

  assign nnc = DN'(sq5_q[0]) + DN'(sq5_q[1]) + DN'(sq5_q[2]);

  always_ff @(posedge clk_i) begin
    nn4_6_q  <= degen5_q ? (DN'(nnd5_q) << 2) : (nnc << 2);
    den6_q   <= degen5_q ? DW'(1) : DW'(dd5_q);
    ddf6_q   <= DW'(dd5_q);
    degen6_q <= degen5_q;
    for (int i = 0; i < 3; i++) begin
      num6_q[i] <= num5_q[i];
      sgn6_q[i] <= sgn5_q[i];
      o6_q[i]   <= o5_q[i];
    end
  end

  // Foot path: three dividers, (dot*d_i) / |D|^2.
  logic [FQ-1:0] fq   [3];
  logic [DW-1:0] frem [3];
  logic [DW-1:0] fden [3];

  for (genvar i = 0; i < 3; i++) begin : g_fdiv
    plfd_div #(.NW(FN), .DW(DW), .QW(FQ)) u_div (
      .clk_i (clk_i),
      .num_i (num6_q[i]),
      .den_i (ddf6_q),
      .quo_o (fq[i]),
      .rem_o (frem[i]),
      .den_o (fden[i])
    );
  end

  logic [SbW-1:0] sb_in;
  logic [SbW-1:0] sb_out;

  assign sb_in = {o6_q[0], o6_q[1], o6_q[2], sgn6_q[0], sgn6_q[1], sgn6_q[2], degen6_q};

  plfd_delay #(.W(SbW), .N(FQ)) u_sb_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (sb_in),
    .q_o    (sb_out)
  );

  // FR1: round half away from zero on the magnitude.
  logic        [FQ:0] qr_q [3];
  logic signed [31:0] of_q [3];
  logic               sf_q [3];
  logic               degf_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      qr_q[i] <= (FQ+1)'(fq[i]) +
                 (FQ+1)'({frem[i], 1'b0} >= {1'b0, fden[i]});
      of_q[i] <= sb_out[SbW-1-32*i -: 32];
      sf_q[i] <= sb_out[3-i];
    end
    degf_q <= sb_out[0];
  end

  // FR2: apply to the line point and clip.
  logic signed [FQ+1:0] fsum [3];
  logic          [31:0] fcl  [3];
  logic           [2:0] fovf;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (degf_q) begin
        fsum[i] = (FQ+2)'(of_q[i]);
      end else if (sf_q[i]) begin
        fsum[i] = (FQ+2)'(of_q[i]) - $signed({1'b0, qr_q[i]});
      end else begin
        fsum[i] = (FQ+2)'(of_q[i]) + $signed({1'b0, qr_q[i]});
      end
      fovf[i] = (fsum[i][FQ+1:31] != {(FQ-29){fsum[i][31]}});
      if (fovf[i]) begin
        fcl[i] = fsum[i][FQ+1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        fcl[i] = fsum[i][31:0];
      end
    end
  end

  logic [FtW-1:0] ft_q;
  logic [FtW-1:0] ft_out;

  always_ff @(posedge clk_i) begin
    ft_q <= {fcl[0], fcl[1], fcl[2], |fovf, degf_q};
  end

  plfd_delay #(.W(FtW), .N(plfd_pkg::FootTail)) u_ft_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (ft_q),
    .q_o    (ft_out)
  );

  // Distance path: floor(4|PxD|^2 / |D|^2), then its square root.
  logic [DQ-1:0] y_quo;
  logic [DW-1:0] y_rem;
  logic [DW-1:0] y_den;
  logic [RN-1:0] root;

  plfd_div #(.NW(DN), .DW(DW), .QW(DQ)) u_ddiv (
    .clk_i (clk_i),
    .num_i (nn4_6_q),
    .den_i (den6_q),
    .quo_o (y_quo),
    .rem_o (y_rem),
    .den_o (y_den)
  );

  plfd_sqrt #(.IW(DQ)) u_sqrt (
    .clk_i  (clk_i),
    .op_i   (y_quo),
    .root_o (root)
  );

  // root is 2*distance; halve with round half up.
  logic [RN:0]   dsum;
  logic [RN-1:0] dist_rnd;
  logic          dsat;

  assign dsum     = (RN+1)'(root) + (RN+1)'(1);
  assign dist_rnd = dsum[RN:1];
  assign dsat     = (dist_rnd[RN-1:32] != '0);

  // Valid for the output register.
  logic vld_out;

  plfd_delay #(.W(1), .N(DQ + RN)) u_vld_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (vld_q[plfd_pkg::FrontStages-1]),
    .q_o    (vld_out)
  );

  // Output register.
  logic           done_q;
  plfd_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_out) begin
      res_q.foot_x     <= ft_out[FtW-1 -: 32];
      res_q.foot_y     <= ft_out[FtW-33 -: 32];
      res_q.foot_z     <= ft_out[FtW-65 -: 32];
      res_q.distance   <= dsat ? 32'hFFFF_FFFF : dist_rnd[31:0];
      res_q.degenerate <= ft_out[0];
      res_q.saturated  <= ft_out[1] | dsat;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // y_rem and y_den are not needed for the distance.
  logic unused_rem;
  assign unused_rem = ^{y_rem, y_den};

  `PLFD_ASSERT_IMP(a_done_follows, done_o,
    $past(start_i && !busy_o, plfd_pkg::Latency), "result without an item")
  `PLFD_ASSERT(a_item_done, (start_i && !busy_o) |-> ##110 done_o,
    "item lost in pipeline")
  `PLFD_ASSERT_IMP(a_degen_foot, done_o && res_o.degenerate,
    res_o.foot_x == $past(cmd_i.line_x, plfd_pkg::Latency) &&
    res_o.foot_z == $past(cmd_i.line_z, plfd_pkg::Latency),
    "degenerate foot is not the line point")

endmodule

[verif/tb_point_line_foot_and_distance_top.sv]
module tb_point_line_foot_and_distance_top;

  // Wide signed scratch type: 4*|PxD|^2 is below 2^134 and the isqrt trial
  // squares below 2^192, so 272 bits leave plenty of headroom for exact integer math.
  typedef logic signed [271:0] wide_t;

  localparam int unsigned WatchLimit = 4 * plfd_pkg::Latency + 2000;

  // Exact model of the foot/distance computation plus the queue of feet
  // and distances still owed by the pipeline.
  class foot_dist_board;
    plfd_pkg::res_t owed_q[$];

    function automatic wide_t isqrt(wide_t y);
      wide_t root, cand;
      root = '0;
      for (int i = 95; i >= 0; i--) begin
        cand = root | (wide_t'(1) << i);
        if (cand * cand <= y) root = cand;
      end
      return root;
    endfunction

    function automatic plfd_pkg::res_t solve_foot(plfd_pkg::cmd_t c);
      wide_t v[3], d[3], o[3], cr[3];
      wide_t dd, dot, num, mag, q, r, f, nn, den, y, s, dist_v;
      plfd_pkg::res_t res;
      logic [31:0] foot[3];
      logic sat;
      o[0] = wide_t'(c.line_x);
      o[1] = wide_t'(c.line_y);
      o[2] = wide_t'(c.line_z);
      v[0] = wide_t'(c.point_x) - o[0];
      v[1] = wide_t'(c.point_y) - o[1];
      v[2] = wide_t'(c.point_z) - o[2];
      d[0] = wide_t'(c.dir_x);
      d[1] = wide_t'(c.dir_y);
      d[2] = wide_t'(c.dir_z);
      dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
      dot = v[0] * d[0] + v[1] * d[1] + v[2] * d[2];
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        f = o[i];
        if (dd != 0) begin
          // |num|/dd rounded half away from zero, then signed back in
          num = dot * d[i];
          mag = (num < 0) ? -num : num;
          q = mag / dd;
          r = mag % dd;
          if (2 * r >= dd) q = q + 1;
          if (q > (wide_t'(1) << 40)) q = wide_t'(1) << 40;
          f = (num < 0) ? f - q : f + q;
        end
        if (f > wide_t'(32'sh7fffffff)) begin
          f = wide_t'(32'sh7fffffff);
          sat = 1'b1;
        end
        if (f < -(wide_t'(1) << 31)) begin
          f = -(wide_t'(1) << 31);
          sat = 1'b1;
        end
        foot[i] = f[31:0];
      end
      if (dd == 0) begin
        nn = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        den = 1;
      end else begin
        cr[0] = v[1] * d[2] - v[2] * d[1];
        cr[1] = v[2] * d[0] - v[0] * d[2];
        cr[2] = v[0] * d[1] - v[1] * d[0];
        nn = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
        den = dd;
      end
      // sqrt(4*nn/den) at one extra bit, then round half up
      y = (4 * nn) / den;
      s = isqrt(y);
      if (s > (wide_t'(1) << 40)) s = wide_t'(1) << 40;
      dist_v = (s + 1) >>> 1;
      if (dist_v > wide_t'(33'h0ffffffff)) begin
        dist_v = wide_t'(33'h0ffffffff);
        sat = 1'b1;
      end
      res.foot_x = foot[0];
      res.foot_y = foot[1];
      res.foot_z = foot[2];
      res.distance = dist_v[31:0];
      res.degenerate = (dd == 0);
      res.saturated = sat;
      return res;
    endfunction

    function void note_item(plfd_pkg::cmd_t c);
      owed_q.push_back(solve_foot(c));
    endfunction

    // Empty string when the result matches the oldest owed one.
    function string check_result(plfd_pkg::res_t got);
      plfd_pkg::res_t exp;
      string msg;
      if (owed_q.size() == 0) return "result with no item outstanding";
      exp = owed_q.pop_front();
      msg = "";
      if (got.foot_x !== exp.foot_x)
        msg = {msg, $sformatf(" foot_x %h/%h", got.foot_x, exp.foot_x)};
      if (got.foot_y !== exp.foot_y)
        msg = {msg, $sformatf(" foot_y %h/%h", got.foot_y, exp.foot_y)};
      if (got.foot_z !== exp.foot_z)
        msg = {msg, $sformatf(" foot_z %h/%h", got.foot_z, exp.foot_z)};
      if (got.distance !== exp.distance)
        msg = {msg, $sformatf(" distance %h/%h", got.distance, exp.distance)};
      if (got.degenerate !== exp.degenerate)
        msg = {msg, $sformatf(" degenerate %b/%b", got.degenerate, exp.degenerate)};
      if (got.saturated !== exp.saturated)
        msg = {msg, $sformatf(" saturated %b/%b", got.saturated, exp.saturated)};
      return msg;
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  plfd_pkg::cmd_t cmd_i;
  logic done_o;
  plfd_pkg::res_t res_o;

  foot_dist_board board;
  int errors;
  int items_sent;
  int results_seen;
  int degen_seen;
  int sat_seen;
  int idle_cycles;
  int gap_pct;

  point_line_foot_and_distance_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Monitor: inputs are driven with NBAs at the rising edge, so here we see
  // the values that held during the cycle the edge closes.
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start_i && !busy_o) begin
        board.note_item(cmd_i);
      end
      if (done_o) begin
        results_seen++;
        if (res_o.degenerate) degen_seen++;
        if (res_o.saturated) sat_seen++;
        msg = board.check_result(res_o);
        if (msg != "") report(msg);
      end
    end
  end

  // Watchdog: long stretch with neither an accept nor a result.
  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit) begin
      $display("timeout: nothing moved for %0d cycles", WatchLimit);
      $display("FAIL");
      $finish;
    end
  end

  // One coordinate: full range half the time, with a fair share of extremes,
  // zeros and small values so short lines and exact cases show up.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return 32'($signed($urandom_range(0, 8191)) - 4096) << $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic plfd_pkg::cmd_t pick_item();
    plfd_pkg::cmd_t c;
    c.point_x = pick_coord();
    c.point_y = pick_coord();
    c.point_z = pick_coord();
    c.line_x = pick_coord();
    c.line_y = pick_coord();
    c.line_z = pick_coord();
    c.dir_x = pick_coord();
    c.dir_y = pick_coord();
    c.dir_z = pick_coord();
    // zero direction now and then; axis-aligned lines too
    case ($urandom_range(0, 11))
      0: {c.dir_x, c.dir_y, c.dir_z} = '0;
      1: {c.dir_y, c.dir_z} = '0;
      2: c.point_x = c.line_x;
      default: ;
    endcase
    return c;
  endfunction

  // Present one item; start_i stays high across back-to-back items.
  // busy_o is read at the falling edge, where it is stable.
  task automatic send_item(plfd_pkg::cmd_t c);
    bit taken;
    while ($urandom_range(0, 99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= c;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
  endtask

  task automatic go_quiet();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pt(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                         logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    plfd_pkg::cmd_t c;
    c = '{px, py, pz, ox, oy, oz, dx, dy, dz};
    send_item(c);
  endtask

  localparam logic [31:0] MAXV = 32'h7fffffff;
  localparam logic [31:0] MINV = 32'h80000000;
  localparam logic [31:0] ONE = 32'h00010000;

  initial begin
    board = new();
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    degen_seen = 0;
    sat_seen = 0;
    idle_cycles = 0;
    gap_pct = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    cmd_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all zeros, unit axes, zero direction, range extremes.
    send_pt(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pt(ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0);
    send_pt(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0, 0);
    send_pt(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, 0, 0);
    send_pt(MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, 0, 0);
    send_pt(MAXV, MINV, MAXV, MINV, MAXV, MINV, 1, 0, 0);
    send_pt(MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MAXV);
    send_pt(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MINV);
    send_pt(MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV);
    // foot pushed past the top of x, then the bottom
    send_pt(MAXV, MAXV, 0, MAXV, MINV, 0, 1, 1, 0);
    send_pt(MINV, MINV, 0, MINV, MAXV, 0, 1, 1, 0);
    // exact half steps in the foot: ties round away from zero
    send_pt(1, 0, 0, 0, 0, 0, 2, 2, 0);
    send_pt(32'hffffffff, 0, 0, 0, 0, 0, 2, 2, 0);
    send_pt(3, 0, 0, 0, 0, 0, 1, 1, 0);
    // points on the line (zero distance), then points off it
    send_pt(5 * ONE, 5 * ONE, 5 * ONE, ONE, ONE, ONE, ONE, ONE, ONE);
    send_pt(0, 0, 0, 0, 0, 0, MINV, MINV, MINV);
    send_pt(MAXV, 0, 0, 0, 0, 0, MAXV, 0, 0);
    send_pt(0, MAXV, 0, 0, MINV, 0, 0, 0, MINV);
    send_pt(MINV, MAXV, MINV, 0, 0, 0, 1, 32'hffffffff, 1);
    send_pt(32'hdeadbeef, 32'h12345678, 32'h9abcdef0,
            32'h0badf00d, 32'hcafebabe, 32'h55aa55aa, 32'h00000003, 32'hfffffffd, 32'h7);

    // Hold off until the pipeline has drained.
    go_quiet();
    while (board.owed() != 0) @(posedge clk_i);

    // Random: sender gaps 8%, then 62%, then none.
    gap_pct = 8;
    repeat (230) send_item(pick_item());
    gap_pct = 62;
    repeat (230) send_item(pick_item());
    gap_pct = 0;
    repeat (240) send_item(pick_item());

    go_quiet();
    while (board.owed() != 0) @(posedge clk_i);
    repeat (plfd_pkg::Latency + 10) @(posedge clk_i);

    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("  %0d with zero direction, %0d clipped", degen_seen, sat_seen);
    if (errors == 0 && board.owed() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
